// ----- sv/ssba_pkg.sv -----
// Shared types and constants for the swap slot bitmap allocator.
// No dependencies; every other file refers to it by scoped names.
package ssba_pkg;

  localparam int MAX_PAGES_DEF = 4096;

  localparam int ADDR_W     = 64;
  localparam int SIZE_W     = 32;
  localparam int PSIZE_W    = 21;
  localparam int PAGE_CNT_W = 13;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 64;

  localparam int ROW_W  = 64;
  localparam int ROW_AW = 6;

  localparam int DIV_STEPS = SIZE_W;

  localparam logic [CFG_IDX_W-1:0] REG_SWAP_ENABLED = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_STORE_BASE   = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_STORE_SIZE   = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_PAGE_SIZE    = 3'd3;

  localparam logic FUNC_RESERVE = 1'b0;
  localparam logic FUNC_RELEASE = 1'b1;

  localparam logic STATUS_OK   = 1'b0;
  localparam logic STATUS_FAIL = 1'b1;

  typedef enum logic [3:0] {
    ST_CLEAR,
    ST_DIV_CFG,
    ST_IDLE,
    ST_REL_CHK,
    ST_REL_DIV,
    ST_REL_BIT,
    ST_SCAN,
    ST_MUL,
    ST_ADD,
    ST_OUT
  } state_e;

endpackage

// ----- sv/ssba_divider.sv -----
// Iterative restoring divider, one quotient bit per cycle.
// Depends on ssba_pkg for operand widths and the step count.
module ssba_divider (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         start_i,
  input  logic [ssba_pkg::SIZE_W-1:0]  dividend_i,
  input  logic [ssba_pkg::PSIZE_W-1:0] divisor_i,
  output logic                         done_o,
  output logic [ssba_pkg::SIZE_W-1:0]  quotient_o,
  output logic [ssba_pkg::PSIZE_W-1:0] remainder_o
);

  localparam int STEP_W = $clog2(ssba_pkg::DIV_STEPS);

  logic                         busy_q;
  logic                         done_q;
  logic [STEP_W-1:0]            step_q;
  logic [ssba_pkg::SIZE_W-1:0]  quo_q;
  logic [ssba_pkg::PSIZE_W-1:0] rem_q;
  logic [ssba_pkg::PSIZE_W-1:0] dvs_q;
  logic [ssba_pkg::PSIZE_W:0]   trial;
  logic                         fits;

  assign trial = {rem_q, quo_q[ssba_pkg::SIZE_W-1]};
  assign fits  = trial >= {1'b0, dvs_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      step_q <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        step_q <= '0;
      end else if (busy_q) begin
        step_q <= step_q + 1'b1;
        if (step_q == STEP_W'(ssba_pkg::DIV_STEPS - 1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      quo_q <= dividend_i;
      rem_q <= '0;
      dvs_q <= divisor_i;
    end else if (busy_q) begin
      quo_q <= {quo_q[ssba_pkg::SIZE_W-2:0], fits};
      if (fits) begin
        rem_q <= ssba_pkg::PSIZE_W'(trial - {1'b0, dvs_q});
      end else begin
        rem_q <= trial[ssba_pkg::PSIZE_W-1:0];
      end
    end
  end

  assign done_o      = done_q;
  assign quotient_o  = quo_q;
  assign remainder_o = rem_q;

endmodule

// ----- sv/ssba_bitmap.sv -----
// Occupancy bitmap memory, one row of slot bits per address.
// One write and one registered read per cycle; depends on ssba_pkg.
module ssba_bitmap #(
  parameter int ROWS = 64,
  parameter int RA_W = 6
) (
  input  logic                       clk_i,
  input  logic                       rd_en_i,
  input  logic [RA_W-1:0]            rd_row_i,
  output logic [ssba_pkg::ROW_W-1:0] rd_data_o,
  input  logic                       wr_en_i,
  input  logic [RA_W-1:0]            wr_row_i,
  input  logic [ssba_pkg::ROW_W-1:0] wr_data_i
);

  logic [ssba_pkg::ROW_W-1:0] mem_q [ROWS];
  logic [ssba_pkg::ROW_W-1:0] rd_data_q;

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem_q[wr_row_i] <= wr_data_i;
    end
    if (rd_en_i) begin
      rd_data_q <= mem_q[rd_row_i];
    end
  end

  assign rd_data_o = rd_data_q;

endmodule

// ----- sv/swap_slot_bitmap_allocator.sv -----
// Top level of the swap slot bitmap allocator: sequencer, registers, output stage.
// Depends on ssba_pkg, ssba_divider and ssba_bitmap.
//
//   channel  | handshake              | payload
//   ---------+------------------------+--------------------------------------------
//   in       | in_valid_i / in_stall_o  | func_i, release_address_i
//   out      | out_valid_o / out_stall_i| status_o, reserved_address_o, used_pages_o,
//            |                        | total_pages_o, ready_res_o
//   cfg      | cfg_valid_i / cfg_ready_o| cfg_index_i, cfg_data_i
//
// Reserve: bitmap rows are scanned from row 0, one bitmap row read per cycle.
// Release: waits on the 32-step shared divider.
// Failures found at acceptance go straight to the output stage; a release outside
// the region fails at the range check. After reset and after every register write a
// clearing pass over all ROWS rows plus a page count division runs; no item is
// taken meanwhile. A stalled result holds; the next item is taken while it waits.
module swap_slot_bitmap_allocator #(
  parameter int MAX_PAGES = ssba_pkg::MAX_PAGES_DEF
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             in_valid_i,
  output logic                             in_stall_o,
  input  logic                             func_i,
  input  logic [ssba_pkg::ADDR_W-1:0]      release_address_i,
  output logic                             out_valid_o,
  input  logic                             out_stall_i,
  output logic                             status_o,
  output logic [ssba_pkg::ADDR_W-1:0]      reserved_address_o,
  output logic [ssba_pkg::PAGE_CNT_W-1:0]  used_pages_o,
  output logic [ssba_pkg::PAGE_CNT_W-1:0]  total_pages_o,
  output logic                             ready_res_o,
  input  logic                             cfg_valid_i,
  output logic                             cfg_ready_o,
  input  logic [ssba_pkg::CFG_IDX_W-1:0]   cfg_index_i,
  input  logic [ssba_pkg::CFG_DATA_W-1:0]  cfg_data_i
);

  localparam int ROWS   = (MAX_PAGES + ssba_pkg::ROW_W - 1) / ssba_pkg::ROW_W;
  localparam int RA_W   = (ROWS > 1) ? $clog2(ROWS) : 1;
  localparam int SLOT_W = RA_W + ssba_pkg::ROW_AW;
  localparam int CNT_W  = $clog2(MAX_PAGES + 1);
  localparam int PROD_W = SLOT_W + ssba_pkg::PSIZE_W;

  function automatic logic [ssba_pkg::ROW_AW-1:0] first_one(
    input logic [ssba_pkg::ROW_W-1:0] v
  );
    logic [ssba_pkg::ROW_AW-1:0] r;
    r = '0;
    for (int i = ssba_pkg::ROW_W - 1; i >= 0; i--) begin
      if (v[i]) begin
        r = ssba_pkg::ROW_AW'(i);
      end
    end
    return r;
  endfunction

  ssba_pkg::state_e state_q, state_d;

  logic                         en_q;
  logic [ssba_pkg::ADDR_W-1:0]  base_q;
  logic [ssba_pkg::SIZE_W-1:0]  size_q;
  logic [ssba_pkg::PSIZE_W-1:0] ps_q;
  logic                         cfg_hit;

  logic [RA_W-1:0]             row_q, row_d;
  logic [SLOT_W-1:0]           slot_q, slot_d;
  logic [CNT_W-1:0]            used_q, used_d;
  logic [CNT_W-1:0]            usable_q, usable_d;
  logic [ssba_pkg::ADDR_W-1:0] rel_addr_q, rel_addr_d;
  logic [PROD_W-1:0]           prod_q, prod_d;
  logic [ssba_pkg::ADDR_W-1:0] addr_q, addr_d;
  logic                        status_q, status_d;

  logic                            out_valid_q;
  logic                            out_status_q;
  logic [ssba_pkg::ADDR_W-1:0]     out_addr_q;
  logic [ssba_pkg::PAGE_CNT_W-1:0] out_used_q;
  logic [ssba_pkg::PAGE_CNT_W-1:0] out_total_q;
  logic                            out_ready_q;
  logic                            out_load;

  logic                         bm_rd_en;
  logic [RA_W-1:0]              bm_rd_row;
  logic [ssba_pkg::ROW_W-1:0]   bm_rd_data;
  logic                         bm_wr_en;
  logic [RA_W-1:0]              bm_wr_row;
  logic [ssba_pkg::ROW_W-1:0]   bm_wr_data;
  logic [ssba_pkg::ROW_W-1:0]   free_bits;
  logic [ssba_pkg::ROW_AW-1:0]  free_pos;

  logic                         div_start;
  logic [ssba_pkg::SIZE_W-1:0]  div_dividend;
  logic                         div_done;
  logic [ssba_pkg::SIZE_W-1:0]  div_quo;
  logic [ssba_pkg::PSIZE_W-1:0] div_rem;

  logic [ssba_pkg::ADDR_W:0]    rel_diff;
  logic                         rel_in_range;
  logic                         accept;

  always_comb begin
    case (cfg_index_i)
      ssba_pkg::REG_SWAP_ENABLED,
      ssba_pkg::REG_STORE_BASE,
      ssba_pkg::REG_STORE_SIZE,
      ssba_pkg::REG_PAGE_SIZE: cfg_hit = cfg_valid_i;
      default:                 cfg_hit = 1'b0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      en_q   <= 1'b0;
      base_q <= '0;
      size_q <= '0;
      ps_q   <= '0;
    end else if (cfg_valid_i) begin
      case (cfg_index_i)
        ssba_pkg::REG_SWAP_ENABLED: en_q   <= cfg_data_i[0];
        ssba_pkg::REG_STORE_BASE:   base_q <= cfg_data_i;
        ssba_pkg::REG_STORE_SIZE:   size_q <= cfg_data_i[ssba_pkg::SIZE_W-1:0];
        ssba_pkg::REG_PAGE_SIZE:    ps_q   <= cfg_data_i[ssba_pkg::PSIZE_W-1:0];
        default: ;
      endcase
    end
  end

  assign cfg_ready_o = 1'b1;

  assign accept       = in_valid_i && (state_q == ssba_pkg::ST_IDLE);
  assign free_bits    = ~bm_rd_data;
  assign free_pos     = first_one(free_bits);
  assign rel_diff     = {1'b0, rel_addr_q} - {1'b0, base_q};
  assign rel_in_range = !rel_diff[ssba_pkg::ADDR_W]
                     && (rel_diff[ssba_pkg::ADDR_W-1:ssba_pkg::SIZE_W] == '0)
                     && (rel_diff[ssba_pkg::SIZE_W-1:0] < size_q);
  assign div_dividend = (state_q == ssba_pkg::ST_REL_CHK) ?
                        rel_diff[ssba_pkg::SIZE_W-1:0] : size_q;
  assign out_load     = (state_q == ssba_pkg::ST_OUT) && (!out_valid_q || !out_stall_i);

  always_comb begin
    state_d    = state_q;
    row_d      = row_q;
    slot_d     = slot_q;
    used_d     = used_q;
    usable_d   = usable_q;
    rel_addr_d = rel_addr_q;
    prod_d     = prod_q;
    addr_d     = addr_q;
    status_d   = status_q;
    bm_rd_en   = 1'b0;
    bm_rd_row  = '0;
    bm_wr_en   = 1'b0;
    bm_wr_row  = row_q;
    bm_wr_data = '0;
    div_start  = 1'b0;

    case (state_q)
      ssba_pkg::ST_CLEAR: begin
        bm_wr_en = 1'b1;
        if (row_q == RA_W'(ROWS - 1)) begin
          div_start = 1'b1;
          state_d   = ssba_pkg::ST_DIV_CFG;
        end else begin
          row_d = row_q + 1'b1;
        end
      end
      ssba_pkg::ST_DIV_CFG: begin
        if (div_done) begin
          if (en_q && (base_q != '0) && (ps_q != '0) && (div_quo != '0)
              && (div_quo <= ssba_pkg::SIZE_W'(MAX_PAGES))) begin
            usable_d = CNT_W'(div_quo);
          end else begin
            usable_d = '0;
          end
          state_d = ssba_pkg::ST_IDLE;
        end
      end
      ssba_pkg::ST_IDLE: begin
        if (accept) begin
          status_d   = ssba_pkg::STATUS_FAIL;
          addr_d     = '0;
          rel_addr_d = release_address_i;
          if (usable_q == '0) begin
            state_d = ssba_pkg::ST_OUT;
          end else if (func_i == ssba_pkg::FUNC_RELEASE) begin
            state_d = ssba_pkg::ST_REL_CHK;
          end else if (used_q >= usable_q) begin
            state_d = ssba_pkg::ST_OUT;
          end else begin
            row_d     = '0;
            bm_rd_en  = 1'b1;
            bm_rd_row = '0;
            state_d   = ssba_pkg::ST_SCAN;
          end
        end
      end
      ssba_pkg::ST_REL_CHK: begin
        if (rel_in_range) begin
          div_start = 1'b1;
          state_d   = ssba_pkg::ST_REL_DIV;
        end else begin
          state_d = ssba_pkg::ST_OUT;
        end
      end
      ssba_pkg::ST_REL_DIV: begin
        if (div_done) begin
          if ((div_rem == '0) && (div_quo < ssba_pkg::SIZE_W'(usable_q))) begin
            slot_d    = div_quo[SLOT_W-1:0];
            bm_rd_en  = 1'b1;
            bm_rd_row = div_quo[SLOT_W-1:ssba_pkg::ROW_AW];
            state_d   = ssba_pkg::ST_REL_BIT;
          end else begin
            state_d = ssba_pkg::ST_OUT;
          end
        end
      end
      ssba_pkg::ST_REL_BIT: begin
        if (bm_rd_data[slot_q[ssba_pkg::ROW_AW-1:0]]) begin
          bm_wr_en   = 1'b1;
          bm_wr_row  = slot_q[SLOT_W-1:ssba_pkg::ROW_AW];
          bm_wr_data = bm_rd_data
                     & ~(ssba_pkg::ROW_W'(1) << slot_q[ssba_pkg::ROW_AW-1:0]);
          if (used_q != '0) begin
            used_d = used_q - 1'b1;
          end
          status_d = ssba_pkg::STATUS_OK;
        end
        state_d = ssba_pkg::ST_OUT;
      end
      ssba_pkg::ST_SCAN: begin
        if (free_bits != '0) begin
          slot_d     = {row_q, free_pos};
          bm_wr_en   = 1'b1;
          bm_wr_row  = row_q;
          bm_wr_data = bm_rd_data | (ssba_pkg::ROW_W'(1) << free_pos);
          used_d     = used_q + 1'b1;
          state_d    = ssba_pkg::ST_MUL;
        end else if (row_q == RA_W'(ROWS - 1)) begin
          state_d = ssba_pkg::ST_OUT;
        end else begin
          row_d     = row_q + 1'b1;
          bm_rd_en  = 1'b1;
          bm_rd_row = row_q + 1'b1;
        end
      end
      ssba_pkg::ST_MUL: begin
        prod_d  = PROD_W'(slot_q) * PROD_W'(ps_q);
        state_d = ssba_pkg::ST_ADD;
      end
      ssba_pkg::ST_ADD: begin
        addr_d   = base_q + ssba_pkg::ADDR_W'(prod_q);
        status_d = ssba_pkg::STATUS_OK;
        state_d  = ssba_pkg::ST_OUT;
      end
      ssba_pkg::ST_OUT: begin
        if (out_load) begin
          state_d = ssba_pkg::ST_IDLE;
        end
      end
      default: begin
        state_d = ssba_pkg::ST_CLEAR;
        row_d   = '0;
      end
    endcase

    if (cfg_hit) begin
      state_d  = ssba_pkg::ST_CLEAR;
      row_d    = '0;
      used_d   = '0;
      usable_d = '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ssba_pkg::ST_CLEAR;
      row_q       <= '0;
      used_q      <= '0;
      usable_q    <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q  <= state_d;
      row_q    <= row_d;
      used_q   <= used_d;
      usable_q <= usable_d;
      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    slot_q     <= slot_d;
    rel_addr_q <= rel_addr_d;
    prod_q     <= prod_d;
    addr_q     <= addr_d;
    status_q   <= status_d;
    if (out_load) begin
      out_status_q <= status_q;
      out_addr_q   <= addr_q;
      out_used_q   <= ssba_pkg::PAGE_CNT_W'(used_q);
      out_total_q  <= ssba_pkg::PAGE_CNT_W'(usable_q);
      out_ready_q  <= (usable_q != '0);
    end
  end

  ssba_divider u_divider (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .start_i     (div_start),
    .dividend_i  (div_dividend),
    .divisor_i   (ps_q),
    .done_o      (div_done),
    .quotient_o  (div_quo),
    .remainder_o (div_rem)
  );

  ssba_bitmap #(
    .ROWS (ROWS),
    .RA_W (RA_W)
  ) u_bitmap (
    .clk_i     (clk_i),
    .rd_en_i   (bm_rd_en),
    .rd_row_i  (bm_rd_row),
    .rd_data_o (bm_rd_data),
    .wr_en_i   (bm_wr_en),
    .wr_row_i  (bm_wr_row),
    .wr_data_i (bm_wr_data)
  );

  assign in_stall_o         = (state_q != ssba_pkg::ST_IDLE);
  assign out_valid_o        = out_valid_q;
  assign status_o           = out_status_q;
  assign reserved_address_o = out_addr_q;
  assign used_pages_o       = out_used_q;
  assign total_pages_o      = out_total_q;
  assign ready_res_o        = out_ready_q;

endmodule

// ----- sv/ssba_checker.sv -----
// Port-level checks for the swap slot bitmap allocator, bound to the top level.
// Depends on ssba_pkg and on the port list of swap_slot_bitmap_allocator.
module ssba_checker (
  input logic                             clk_i,
  input logic                             rst_ni,
  input logic                             out_valid_o,
  input logic                             out_stall_i,
  input logic                             status_o,
  input logic [ssba_pkg::ADDR_W-1:0]      reserved_address_o,
  input logic [ssba_pkg::PAGE_CNT_W-1:0]  used_pages_o,
  input logic [ssba_pkg::PAGE_CNT_W-1:0]  total_pages_o,
  input logic                             ready_res_o
);

  a_ready_total: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (ready_res_o == (total_pages_o != '0)))
    else $error("ready flag disagrees with total page count");

  a_fail_no_addr: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && (status_o == ssba_pkg::STATUS_FAIL)) |-> (reserved_address_o == '0))
    else $error("failed item carries an address");

  a_not_ready_fails: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !ready_res_o) |-> (status_o == ssba_pkg::STATUS_FAIL))
    else $error("item succeeded while allocator not ready");

  a_used_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (used_pages_o <= total_pages_o))
    else $error("used pages exceed total pages");

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_stall_i) |=> (out_valid_o && $stable(status_o)
      && $stable(reserved_address_o) && $stable(used_pages_o)))
    else $error("stalled result changed");

endmodule

bind swap_slot_bitmap_allocator ssba_checker u_checker (.*);
